FILE: hdl/idmt_pkg.sv
// ----------------------------------------------------------------------------
// ID mapping table package
// Shared types, opcodes, register indexes and reset values of the
// (local id, file id) to slot mapping table.
// ----------------------------------------------------------------------------
package idmt_pkg;

  // Field widths of the transaction payloads.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned ID_W    = 16;
  localparam int unsigned FILE_W  = 32;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned FNS_W   = 9;
  localparam int unsigned LIMIT_W = 10;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Default sizes of the two tables.
  localparam int unsigned MAP_SLOTS_DEF = 512;
  localparam int unsigned OVR_SLOTS_DEF = 256;

  // Register reset values.
  localparam logic [FNS_W-1:0]   FNS_RST    = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 10'd512;
  localparam logic [ID_W-1:0]    MARKER_RST = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_ALLOCATE   = 3'd1,
    OP_ADD_OVR    = 3'd2,
    OP_CLEAR_MAP  = 3'd3,
    OP_CLEAR_OVR  = 3'd4,
    OP_READ_ENTRY = 3'd5,
    OP_READ_OVR   = 3'd6
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_NEW_SLOT = 2'd0,
    CFG_ENTITY_LIMIT   = 2'd1,
    CFG_INVALID_MARKER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    op_e               opcode;
    logic [ID_W-1:0]   local_id;
    logic [FILE_W-1:0] file_id;
    logic [ID_W-1:0]   substitute;
    logic [IDX_W-1:0]  slot_index;
  } item_t;

  typedef struct packed {
    logic [FNS_W-1:0]   first_new_slot;
    logic [LIMIT_W-1:0] entity_limit;
    logic [ID_W-1:0]    invalid_marker;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic              hit;
    logic [ID_W-1:0]   entry_local_id;
    logic [FILE_W-1:0] entry_file_id;
    logic [ID_W-1:0]   entry_substitute;
  } rsp_t;

  // One mapping slot and one override slot as stored in memory.
  typedef struct packed {
    logic [ID_W-1:0]   local_id;
    logic [FILE_W-1:0] file_id;
    logic [ID_W-1:0]   substitute;
  } map_ent_t;

  typedef struct packed {
    logic [ID_W-1:0]   local_id;
    logic [FILE_W-1:0] file_id;
  } ovr_ent_t;

endpackage

FILE: hdl/id_mapping_table_allocator.sv
// ----------------------------------------------------------------------------
// ID mapping table allocator
// Translates (local id, file id) pairs into slot numbers, allocates the
// first free slot on an allocate miss and keeps a table of override slots.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  opcode, local_id, file_id,
//                                              substitute, slot_index
//   out      output     out_valid_o/out_ready_i result_id, hit, entry_*
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Lookup and allocate scan the mapping RAM one slot per cycle through its
// single read port over slots below min(entity_limit, MAP_SLOTS), ending
// early on a match. Add override and the two reads read a single entry.
// Clear mappings and clear overrides write one RAM entry per cycle.
// After reset a clearing pass over both tables runs with in_ready_o low;
// configuration writes are taken throughout.
// One transaction is worked on at a time; a finished result waits in the
// output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module id_mapping_table_allocator #(
  parameter int unsigned MAP_SLOTS      = idmt_pkg::MAP_SLOTS_DEF,
  parameter int unsigned OVERRIDE_SLOTS = idmt_pkg::OVR_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input transactions.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [idmt_pkg::OP_W-1:0]         opcode_i,
  input  logic [idmt_pkg::ID_W-1:0]         local_id_i,
  input  logic [idmt_pkg::FILE_W-1:0]       file_id_i,
  input  logic [idmt_pkg::ID_W-1:0]         substitute_i,
  input  logic [idmt_pkg::IDX_W-1:0]        slot_index_i,
  // Result transactions.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [idmt_pkg::ID_W-1:0]         result_id_o,
  output logic                              hit_o,
  output logic [idmt_pkg::ID_W-1:0]         entry_local_id_o,
  output logic [idmt_pkg::FILE_W-1:0]       entry_file_id_o,
  output logic [idmt_pkg::ID_W-1:0]         entry_substitute_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [idmt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [idmt_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SLOT_MAX = (MAP_SLOTS > OVERRIDE_SLOTS) ? MAP_SLOTS : OVERRIDE_SLOTS;

  idmt_pkg::cfg_t  cfg_q;
  idmt_pkg::item_t item;
  idmt_pkg::rsp_t  seq_rsp, out_q;
  logic            seq_idle, seq_rsp_valid, out_load, out_valid_q;

  // Configuration registers; writes beyond the register list are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_new_slot <= idmt_pkg::FNS_RST;
      cfg_q.entity_limit   <= idmt_pkg::LIMIT_RST;
      cfg_q.invalid_marker <= idmt_pkg::MARKER_RST;
    end else if (cfg_valid_i) begin
      unique case (idmt_pkg::cfg_idx_e'(cfg_index_i))
        idmt_pkg::CFG_FIRST_NEW_SLOT: cfg_q.first_new_slot <= cfg_data_i[idmt_pkg::FNS_W-1:0];
        idmt_pkg::CFG_ENTITY_LIMIT:   cfg_q.entity_limit   <= cfg_data_i[idmt_pkg::LIMIT_W-1:0];
        idmt_pkg::CFG_INVALID_MARKER: cfg_q.invalid_marker <= cfg_data_i[idmt_pkg::ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input transaction.
  always_comb begin
    item.opcode     = idmt_pkg::op_e'(opcode_i);
    item.local_id   = local_id_i;
    item.file_id    = file_id_i;
    item.substitute = substitute_i;
    item.slot_index = slot_index_i;
  end

  assign in_ready_o = seq_idle;

  idmt_seq #(
    .MAP_SLOTS      (MAP_SLOTS),
    .OVERRIDE_SLOTS (OVERRIDE_SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .idle_o      (seq_idle),
    .rsp_valid_o (seq_rsp_valid),
    .rsp_o       (seq_rsp),
    .rsp_take_i  (out_load)
  );

  // Output register: loads a finished result whenever it is free or draining.
  assign out_load = seq_rsp_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= seq_rsp;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_id_o        = out_q.result_id;
  assign hit_o              = out_q.hit;
  assign entry_local_id_o   = out_q.entry_local_id;
  assign entry_file_id_o    = out_q.entry_file_id;
  assign entry_substitute_o = out_q.entry_substitute;

  // An accepted transaction makes the sequencer busy, so in_ready_o drops.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // A miss never carries entry contents.
  a_miss_no_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |->
      (entry_local_id_o == '0) && (entry_file_id_o == '0) && (entry_substitute_o == '0))
    else $error("miss result with entry data");

  // A hit always names a slot that exists.
  a_hit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> (32'(result_id_o) < 32'(SLOT_MAX)))
    else $error("hit result outside the tables");

endmodule

FILE: hdl/idmt_ram.sv
// ----------------------------------------------------------------------------
// ID mapping table RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module idmt_ram #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/idmt_seq.sv
// ----------------------------------------------------------------------------
// ID mapping table sequencer
// Holds both tables and runs each operation one step per cycle, then holds its
// result until taken: slot scans on one key comparator, reads, clearing sweeps.
// ----------------------------------------------------------------------------
module idmt_seq #(
  parameter int unsigned MAP_SLOTS      = idmt_pkg::MAP_SLOTS_DEF,
  parameter int unsigned OVERRIDE_SLOTS = idmt_pkg::OVR_SLOTS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  idmt_pkg::item_t item_i,
  input  idmt_pkg::cfg_t  cfg_i,
  output logic            idle_o,
  output logic            rsp_valid_o,
  output idmt_pkg::rsp_t  rsp_o,
  input  logic            rsp_take_i
);

  localparam int unsigned MAP_AW  = $clog2(MAP_SLOTS);
  localparam int unsigned OVR_AW  = (OVERRIDE_SLOTS > 1) ? $clog2(OVERRIDE_SLOTS) : 1;
  localparam int unsigned MAP_CW  = $clog2(MAP_SLOTS + 1);
  localparam int unsigned CW      = (MAP_CW > idmt_pkg::LIMIT_W) ? MAP_CW : idmt_pkg::LIMIT_W;
  localparam int unsigned SW_MAX  = (MAP_SLOTS > OVERRIDE_SLOTS) ? MAP_SLOTS : OVERRIDE_SLOTS;
  localparam int unsigned SW      = $clog2(SW_MAX + 1);
  localparam int unsigned NW      = (CW > SW) ? CW : SW;
  localparam int unsigned MAP_EW  = $bits(idmt_pkg::map_ent_t);
  localparam int unsigned OVR_EW  = $bits(idmt_pkg::ovr_ent_t);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_RDREQ = 7'b0001000,
    S_RDCHK = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                state_q, state_d;
  logic [NW-1:0]         cnt_q, cnt_d;
  logic                  chk_vld_q, chk_vld_d;
  logic [MAP_AW-1:0]     chk_idx_q, chk_idx_d;
  logic                  free_vld_q, free_vld_d;
  logic [MAP_AW-1:0]     free_idx_q, free_idx_d;
  logic                  swp_map_q, swp_map_d;
  logic                  swp_ovr_q, swp_ovr_d;
  logic [idmt_pkg::ID_W-1:0] swp_marker_q, swp_marker_d;
  idmt_pkg::item_t       item_q, item_d;
  idmt_pkg::rsp_t        rsp_q, rsp_d;

  // Memory ports.
  logic                  map_we, map_re;
  logic [MAP_AW-1:0]     map_waddr, map_raddr;
  idmt_pkg::map_ent_t    map_wdata, map_rdata;
  logic                  ovr_we, ovr_re;
  logic [OVR_AW-1:0]     ovr_waddr, ovr_raddr;
  idmt_pkg::ovr_ent_t    ovr_wdata, ovr_rdata;

  // Widened operands, all compared at one width.
  logic [NW-1:0] map_n, ovr_n, lim_raw_n, lim_n, fns_n, idx_n, chk_n, cnt_nx;
  logic          key_match, slot_empty, ovr_ok;

  idmt_ram #(.W(MAP_EW), .DEPTH(MAP_SLOTS), .AW(MAP_AW)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  idmt_ram #(.W(OVR_EW), .DEPTH(OVERRIDE_SLOTS), .AW(OVR_AW)) u_ovr_ram (
    .clk_i   (clk_i),
    .we_i    (ovr_we),
    .waddr_i (ovr_waddr),
    .wdata_i (ovr_wdata),
    .re_i    (ovr_re),
    .raddr_i (ovr_raddr),
    .rdata_o (ovr_rdata)
  );

  // Operand widening and the effective slot limit.
  always_comb begin
    map_n     = NW'(MAP_SLOTS);
    ovr_n     = NW'(OVERRIDE_SLOTS);
    lim_raw_n = NW'(cfg_i.entity_limit);
    lim_n     = (lim_raw_n < map_n) ? lim_raw_n : map_n;
    fns_n     = NW'(cfg_i.first_new_slot);
    idx_n     = NW'(item_q.slot_index);
    chk_n     = NW'(chk_idx_q);
    cnt_nx    = cnt_q + NW'(1);
    ovr_ok    = (idx_n < fns_n) && (idx_n < ovr_n);
  end

  // Shared comparator: stored pair against the key, and against empty.
  assign key_match  = (map_rdata.local_id == item_q.local_id) &&
                      (map_rdata.file_id == item_q.file_id);
  assign slot_empty = (map_rdata.local_id == '0) && (map_rdata.file_id == '0);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    free_vld_d   = free_vld_q;
    free_idx_d   = free_idx_q;
    swp_map_d    = swp_map_q;
    swp_ovr_d    = swp_ovr_q;
    swp_marker_d = swp_marker_q;
    item_d       = item_q;
    rsp_d        = rsp_q;

    map_we    = 1'b0;
    map_waddr = cnt_q[MAP_AW-1:0];
    map_wdata = '0;
    map_re    = 1'b0;
    map_raddr = cnt_q[MAP_AW-1:0];
    ovr_we    = 1'b0;
    ovr_waddr = cnt_q[OVR_AW-1:0];
    ovr_wdata = '{local_id: swp_marker_q, file_id: '0};
    ovr_re    = 1'b0;
    ovr_raddr = idx_n[OVR_AW-1:0];

    unique case (state_q)
      // Clearing sweeps, after reset and on the two clear opcodes.
      S_INIT, S_CLEAR: begin
        map_we = swp_map_q && (cnt_q < map_n);
        ovr_we = swp_ovr_q && (cnt_q < ovr_n);
        if ((swp_map_q && (cnt_nx < map_n)) || (swp_ovr_q && (cnt_nx < ovr_n))) begin
          cnt_d = cnt_nx;
        end else begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_DONE;
        end
      end

      S_IDLE: begin
        if (start_i) begin
          item_d     = item_i;
          rsp_d      = '0;
          rsp_d.result_id = cfg_i.invalid_marker;
          cnt_d      = '0;
          chk_vld_d  = 1'b0;
          free_vld_d = 1'b0;
          unique case (item_i.opcode) inside
            idmt_pkg::OP_LOOKUP, idmt_pkg::OP_ALLOCATE: begin
              state_d = S_SCAN;
            end
            idmt_pkg::OP_ADD_OVR, idmt_pkg::OP_READ_ENTRY, idmt_pkg::OP_READ_OVR: begin
              state_d = S_RDREQ;
            end
            idmt_pkg::OP_CLEAR_MAP: begin
              swp_map_d = 1'b1;
              swp_ovr_d = 1'b0;
              state_d   = S_CLEAR;
            end
            idmt_pkg::OP_CLEAR_OVR: begin
              swp_map_d    = 1'b0;
              swp_ovr_d    = 1'b1;
              swp_marker_d = cfg_i.invalid_marker;
              state_d      = S_CLEAR;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // One slot read is issued per cycle; its data is checked the cycle after.
      S_SCAN: begin
        if (cnt_q < lim_n) begin
          map_re    = 1'b1;
          map_raddr = cnt_q[MAP_AW-1:0];
          cnt_d     = cnt_nx;
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[MAP_AW-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if (key_match) begin
            rsp_d.result_id = idmt_pkg::ID_W'(chk_idx_q);
            rsp_d.hit       = 1'b1;
            chk_vld_d       = 1'b0;
            state_d         = S_DONE;
          end else if (slot_empty && (chk_n >= fns_n) && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
        end else if (cnt_q >= lim_n) begin
          // Scan over without a match: an allocate claims the first free slot.
          if ((item_q.opcode == idmt_pkg::OP_ALLOCATE) && free_vld_q) begin
            map_we          = 1'b1;
            map_waddr       = free_idx_q;
            map_wdata       = '{local_id:   item_q.local_id,
                                file_id:    item_q.file_id,
                                substitute: item_q.substitute};
            rsp_d.result_id = idmt_pkg::ID_W'(free_idx_q);
            rsp_d.hit       = 1'b1;
          end
          state_d = S_DONE;
        end
      end

      S_RDREQ: begin
        map_re    = 1'b1;
        map_raddr = idx_n[MAP_AW-1:0];
        ovr_re    = 1'b1;
        state_d   = S_RDCHK;
      end

      S_RDCHK: begin
        case (item_q.opcode)
          idmt_pkg::OP_ADD_OVR: begin
            if (ovr_ok && (ovr_rdata.local_id == cfg_i.invalid_marker)) begin
              ovr_we          = 1'b1;
              ovr_waddr       = idx_n[OVR_AW-1:0];
              ovr_wdata       = '{local_id: item_q.local_id, file_id: item_q.file_id};
              rsp_d.result_id = idmt_pkg::ID_W'(item_q.slot_index);
              rsp_d.hit       = 1'b1;
            end
          end
          idmt_pkg::OP_READ_ENTRY: begin
            if (idx_n < map_n) begin
              rsp_d.result_id        = idmt_pkg::ID_W'(item_q.slot_index);
              rsp_d.hit              = 1'b1;
              rsp_d.entry_local_id   = map_rdata.local_id;
              rsp_d.entry_file_id    = map_rdata.file_id;
              rsp_d.entry_substitute = map_rdata.substitute;
            end
          end
          idmt_pkg::OP_READ_OVR: begin
            if (ovr_ok) begin
              rsp_d.result_id      = idmt_pkg::ID_W'(item_q.slot_index);
              rsp_d.hit            = 1'b1;
              rsp_d.entry_local_id = ovr_rdata.local_id;
              rsp_d.entry_file_id  = ovr_rdata.file_id;
            end
          end
          default: begin
          end
        endcase
        state_d = S_DONE;
      end

      S_DONE: begin
        if (rsp_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      free_vld_q   <= 1'b0;
      swp_map_q    <= 1'b1;
      swp_ovr_q    <= 1'b1;
      swp_marker_q <= idmt_pkg::MARKER_RST;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      chk_vld_q    <= chk_vld_d;
      free_vld_q   <= free_vld_d;
      swp_map_q    <= swp_map_d;
      swp_ovr_q    <= swp_ovr_d;
      swp_marker_q <= swp_marker_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    item_q     <= item_d;
    rsp_q      <= rsp_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_DONE);
  assign rsp_o       = rsp_q;

endmodule
